// ===== sv/lfu_cache_table_macros.svh =====
// assertion macros for the lfu cache table
// used by the top level only, no other dependencies
`ifndef LFU_CACHE_TABLE_MACROS_SVH
`define LFU_CACHE_TABLE_MACROS_SVH
// same-cycle implication, checked out of reset
`define LFU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, checked out of reset
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== sv/lfu_pkg.sv =====
// shared types and constants for the lfu cache table
// no dependencies
package lfu_pkg;
   localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
   localparam logic        OP_GET     = 1'b0;
   localparam logic        OP_PUT     = 1'b1;
   localparam logic [4:0]  CAP_RESET  = 5'd16;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] req_key;
      logic signed [31:0] req_value;
   } req_beat_type;

   typedef struct packed {
      logic               key_found;
      logic signed [31:0] read_value;
   } rsp_beat_type;

   // entry contents apart from the use count
   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [31:0] value;
      logic [31:0] stamp;
   } entry_body_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_HOLD
   } state_type;
endpackage

// ===== sv/lfu_cell.sv =====
// one cache entry cell of the rotating ring
// depends on lfu_pkg
module lfu_cell import lfu_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift_en,
   input  entry_body_type         in_body,
   input  logic [COUNT_WIDTH-1:0] in_count,
   input  logic [31:0]            search_key,
   output entry_body_type         body_ff,
   output logic [COUNT_WIDTH-1:0] count_ff,
   output logic                   match
);
   // take the neighbour's entry on every shift, valid cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         body_ff.valid <= 1'b0;
      end else if (shift_en) begin
         body_ff <= in_body;
      end
      if (shift_en) begin
         count_ff <= in_count;
      end
   end

   // key compare on the held entry
   assign match = body_ff.valid && (body_ff.key == search_key);
endmodule

// ===== sv/lfu_cache_table.sv =====
// lfu cache table: a ring of CAPACITY entry cells rotates one slot per cycle past the
// head cell while a scan or write-back pass runs. Each accepted request beat goes through
// a scan pass over the ring that finds the key, the first free slot and the
// least-frequently/least-recently used victim, a second pass that writes the chosen
// entry back, a hand-off state that passes the result to the output register and an
// idle state that takes the next request. While the previous result beat has not been
// taken the hand-off state repeats, and the input waits with it. One request is worked
// on at a time.
// depends on lfu_pkg, lfu_cell and lfu_cache_table_macros.svh
`include "lfu_cache_table_macros.svh"
module lfu_cache_table import lfu_pkg::*; #(
   parameter int CAPACITY    = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_data,
   input  logic         csr_we,
   input  logic [4:0]   csr_wdata
);
   localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OW   = $clog2(CAPACITY + 1);
   localparam int CAPW = (OW > 5) ? OW : 5;
   localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);

   state_type state_ff, state_in;
   logic [IW-1:0] step_ff;
   logic [4:0] cap_ff;
   logic [OW-1:0] occ_ff;
   logic [31:0] clock_ff;
   req_beat_type req_ff;
   logic rsp_valid_ff;
   rsp_beat_type rsp_ff;

   // scan trackers
   logic hit_ff, have_v_ff, free_ff;
   logic [IW-1:0] hit_slot_ff, vic_slot_ff, free_slot_ff;
   logic [31:0] hit_value_ff, vic_age_ff;
   logic [COUNT_WIDTH-1:0] vic_count_ff;

   // ring of cells
   entry_body_type cell_body [CAPACITY];
   logic [COUNT_WIDTH-1:0] cell_count [CAPACITY];
   logic cell_match [CAPACITY];
   entry_body_type ring_body;
   logic [COUNT_WIDTH-1:0] ring_count;
   logic shift_en;

   assign shift_en = (state_ff == ST_SCAN) || (state_ff == ST_APPLY);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_body_type nb;
      logic [COUNT_WIDTH-1:0] nc;
      if (i == CAPACITY - 1) begin : g_tail
         assign nb = ring_body;
         assign nc = ring_count;
      end else begin : g_mid
         assign nb = cell_body[i+1];
         assign nc = cell_count[i+1];
      end
      lfu_cell #(.COUNT_WIDTH(COUNT_WIDTH)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .in_body    (nb),
         .in_count   (nc),
         .search_key (req_ff.req_key),
         .body_ff    (cell_body[i]),
         .count_ff   (cell_count[i]),
         .match      (cell_match[i])
      );
   end

   // head cell view
   logic [31:0] head_age;
   logic head_better;
   assign head_age = clock_ff - cell_body[0].stamp;
   assign head_better = !have_v_ff || (cell_count[0] < vic_count_ff) ||
                        ((cell_count[0] == vic_count_ff) && (head_age > vic_age_ff));

   // decision after the scan
   logic [CAPW-1:0] cap_ext, cap_eff, occ_ext;
   logic is_put, cap_on, do_write, do_insert, do_grow;
   logic [IW-1:0] tgt_slot;
   assign cap_ext   = CAPW'(cap_ff);
   assign cap_eff   = (cap_ext > CAPW'(CAPACITY)) ? CAPW'(CAPACITY) : cap_ext;
   assign occ_ext   = CAPW'(occ_ff);
   assign is_put    = (req_ff.req_type == OP_PUT);
   assign cap_on    = (cap_eff != '0);
   assign do_insert = is_put && cap_on && !hit_ff;
   assign do_grow   = do_insert && (occ_ext < cap_eff);
   assign do_write  = hit_ff ? (!is_put || cap_on) : do_insert;
   assign tgt_slot  = hit_ff ? hit_slot_ff : (do_grow ? free_slot_ff : vic_slot_ff);

   // entry going back into the tail cell
   always_comb begin
      ring_body  = cell_body[0];
      ring_count = cell_count[0];
      if (state_ff == ST_APPLY && do_write && step_ff == tgt_slot) begin
         ring_body.stamp = clock_ff + 32'd1;
         if (do_insert) begin
            ring_body.valid = 1'b1;
            ring_body.key   = req_ff.req_key;
            ring_body.value = req_ff.req_value;
            ring_count      = COUNT_WIDTH'(1);
         end else begin
            if (is_put) begin
               ring_body.value = req_ff.req_value;
            end
            if (!(&cell_count[0])) begin
               ring_count = cell_count[0] + COUNT_WIDTH'(1);
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (step_ff == LAST_STEP) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (step_ff == LAST_STEP) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // step counter, capacity register, occupancy and touch clock
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         cap_ff   <= CAP_RESET;
         occ_ff   <= '0;
         clock_ff <= '0;
      end else begin
         if (csr_we) cap_ff <= csr_wdata;
         if (shift_en) begin
            step_ff <= (step_ff == LAST_STEP) ? '0 : step_ff + IW'(1);
         end
         if (state_ff == ST_APPLY && step_ff == LAST_STEP) begin
            if (do_write) clock_ff <= clock_ff + 32'd1;
            if (do_grow) occ_ff <= occ_ff + OW'(1);
         end
      end
   end

   // request capture and scan trackers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff    <= req_data;
         hit_ff    <= 1'b0;
         have_v_ff <= 1'b0;
         free_ff   <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         if (cell_match[0] && !hit_ff) begin
            hit_ff       <= 1'b1;
            hit_slot_ff  <= step_ff;
            hit_value_ff <= cell_body[0].value;
         end
         if (!cell_body[0].valid && !free_ff) begin
            free_ff      <= 1'b1;
            free_slot_ff <= step_ff;
         end
         if (cell_body[0].valid && head_better) begin
            have_v_ff    <= 1'b1;
            vic_slot_ff  <= step_ff;
            vic_count_ff <= cell_count[0];
            vic_age_ff   <= head_age;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_HOLD && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_HOLD && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff.key_found  <= hit_ff;
         rsp_ff.read_value <= (hit_ff && !is_put) ? hit_value_ff : MISS_VALUE;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LFU_ASSERT_NOW(a_occ_bound, 1'b1, occ_ff <= OW'(CAPACITY), "occupancy beyond capacity")
   `LFU_ASSERT_NEXT(a_scan_start, req_valid && req_ready, step_ff == '0 && state_ff == ST_SCAN, "scan start")
   `LFU_ASSERT_NOW(a_rsp_from_hold, $rose(rsp_valid_ff), $past(state_ff) == ST_HOLD, "result outside hold")
endmodule

// ===== bench/lfu_cache_table_tb.sv =====
// testbench for the lfu cache table: directed and random get/put beats checked
// against a behavioural lfu/lru predictor; depends on lfu_pkg and lfu_cache_table
`timescale 1ns / 1ps
module lfu_cache_table_tb;
   import lfu_pkg::*;

   localparam int SLOTS     = 16;
   localparam int COUNT_TOP = 65535;
   localparam int TIMEOUT   = 600000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_beat_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_beat_type rsp_data;
   logic         csr_we;
   logic [4:0]   csr_wdata;

   lfu_cache_table u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [4:0]  cap_reg;
   bit          slot_live [SLOTS];
   logic [31:0] slot_key [SLOTS];
   logic [31:0] slot_val [SLOTS];
   int unsigned slot_uses [SLOTS];
   logic [31:0] slot_stamp [SLOTS];
   int unsigned live_count;
   logic [31:0] touch_clock;

   rsp_beat_type lookup_q [$];
   int     errors;
   int     beats_sent;
   int     beats_checked;
   int     cycles;
   bit     idle_send;
   bit     idle_recv;
   int     hold_cycles;
   logic [31:0] key_pool [8];

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > TIMEOUT) begin
         $display("%0t timeout", $time);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic void mark_touch(int s, bit raise);
      touch_clock = touch_clock + 32'd1;
      slot_stamp[s] = touch_clock;
      if (raise && slot_uses[s] < COUNT_TOP) slot_uses[s]++;
   endfunction

   function automatic int choose_victim();
      int best;
      bit have;
      best = 0;
      have = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!slot_live[i]) continue;
         if (!have) begin
            best = i; have = 1;
         end else if (slot_uses[i] < slot_uses[best]) begin
            best = i;
         end else if (slot_uses[i] == slot_uses[best] &&
                      (touch_clock - slot_stamp[i]) > (touch_clock - slot_stamp[best])) begin
            best = i;
         end
      end
      return best;
   endfunction

   // lfu lookup/update: returns expected response beat
   function automatic rsp_beat_type predict_lookup(req_beat_type r);
      rsp_beat_type o;
      int cap;
      int s;
      bit hit;
      cap = (cap_reg < SLOTS) ? cap_reg : SLOTS;
      hit = 0;
      s = 0;
      o.read_value = MISS_VALUE;
      for (int i = 0; i < SLOTS; i++)
         if (!hit && slot_live[i] && slot_key[i] == r.req_key) begin
            hit = 1; s = i;
         end
      if (r.req_type == OP_GET) begin
         if (hit) begin
            o.read_value = slot_val[s];
            mark_touch(s, 1);
         end
      end else if (cap != 0) begin
         if (hit) begin
            slot_val[s] = r.req_value;
            mark_touch(s, 1);
         end else begin
            if (live_count >= cap) begin
               s = choose_victim();
               slot_live[s] = 0;
               if (live_count > 0) live_count--;
            end else begin
               s = 0;
               while (s < SLOTS && slot_live[s]) s++;
               if (s >= SLOTS) s = choose_victim();
            end
            if (!slot_live[s]) live_count++;
            slot_live[s] = 1;
            slot_key[s] = r.req_key;
            slot_val[s] = r.req_value;
            slot_uses[s] = 1;
            mark_touch(s, 0);
         end
      end
      o.key_found = hit;
      return o;
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lookup_q.size() == 0) begin
            $display("%0t unexpected beat: actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = lookup_q.pop_front();
            beats_checked++;
            if (rsp_data.key_found !== want.key_found) begin
               $display("%0t key_found: expected %0b actual %0b", $time,
                        want.key_found, rsp_data.key_found);
               errors++;
            end
            if (rsp_data.read_value !== want.read_value) begin
               $display("%0t read_value: expected %h actual %h", $time,
                        want.read_value, rsp_data.read_value);
               errors++;
            end
         end
      end
   end

   // receiver: random stalls, a long hold-off, or none
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= idle_recv ? ($urandom_range(99) >= 24) : 1'b1;
      end
   end

   task automatic send_beat(logic op, logic [31:0] key, logic [31:0] value);
      req_beat_type r;
      r.req_type = op;
      r.req_key = key;
      r.req_value = value;
      while (idle_send && $urandom_range(99) < 24) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      lookup_q.push_back(predict_lookup(r));
      beats_sent++;
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (lookup_q.size() != 0) @(posedge clock);
      repeat (2 * SLOTS + 8) @(posedge clock);
   endtask

   task automatic write_capacity(logic [4:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      cap_reg = v;
   endtask

   // extremes of key and value, hits, misses, update, saturation of register
   task automatic test_directed();
      send_beat(OP_GET, 32'h0, 32'h0);
      send_beat(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_beat(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_beat(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(OP_GET, 32'h8000_0000, 32'h1234_5678);
      send_beat(OP_GET, 32'h7FFF_FFFF, 32'h0);
      send_beat(OP_PUT, 32'h8000_0000, 32'h0);
      send_beat(OP_GET, 32'h8000_0000, 32'h0);
      send_beat(OP_GET, 32'h0000_0001, 32'h0);
      write_capacity(5'd31);
      for (int i = 0; i < 18; i++) send_beat(OP_PUT, 32'h100 + i, $urandom);
   endtask

   // capacity zero, then lowered below occupancy, then one
   task automatic test_capacity_edges();
      write_capacity(5'd0);
      send_beat(OP_PUT, 32'h105, 32'hAAAA_5555);
      send_beat(OP_PUT, 32'hDEAD, 32'h1);
      send_beat(OP_GET, 32'h105, 32'h0);
      write_capacity(5'd3);
      send_beat(OP_PUT, 32'hBEEF, 32'h2);
      send_beat(OP_GET, 32'hBEEF, 32'h0);
      write_capacity(5'd1);
      send_beat(OP_PUT, 32'h1, 32'h3);
      send_beat(OP_PUT, 32'h2, 32'h4);
      send_beat(OP_GET, 32'h1, 32'h0);
   endtask

   // random mix from a small key pool so hits and evictions are common
   task automatic test_random(int n, bit busy);
      logic [31:0] k;
      for (int i = 0; i < n; i++) begin
         idle_send = busy;
         if ($urandom_range(9) == 0) k = $urandom;
         else k = key_pool[$urandom_range(7)] + $urandom_range(11);
         send_beat(1'($urandom_range(1)), k, $urandom);
      end
   endtask

   // long receiver hold-off while beats keep coming
   task automatic test_backpressure();
      hold_cycles = 400;
      test_random(40, 0);
   endtask

   initial begin
      errors = 0; beats_sent = 0; beats_checked = 0; cycles = 0;
      hold_cycles = 0; idle_send = 1; idle_recv = 1;
      reset = 1'b1; req_valid = 1'b0; req_data = '0; csr_we = 1'b0; csr_wdata = '0;
      cap_reg = CAP_RESET; live_count = 0; touch_clock = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_live[i] = 0; slot_key[i] = '0; slot_val[i] = '0;
         slot_uses[i] = 0; slot_stamp[i] = '0;
      end
      key_pool[0] = 32'h0; key_pool[1] = 32'hFFFF_FFF0; key_pool[2] = 32'h7FFF_FFF0;
      key_pool[3] = 32'h8000_0000; key_pool[4] = 32'h5555_5555;
      key_pool[5] = 32'hAAAA_AAA0; key_pool[6] = 32'h0000_1000;
      key_pool[7] = 32'h1234_5670;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_capacity_edges();
      write_capacity(5'd16);
      test_random(500, 1);
      write_capacity(5'd4);
      test_random(300, 1);
      idle_recv = 0;
      test_random(200, 0);
      idle_recv = 1;
      test_backpressure();
      write_capacity(5'd9);
      test_random(300, 1);
      write_capacity(5'd17);
      test_random(200, 1);
      drain();

      $display("ran %0d beats, %0d responses checked, capacities 0 to 31 incl. stalls",
               beats_sent, beats_checked);
      if (errors == 0 && lookup_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
